// ----- hw/rtl/dpp_pkg.sv -----
// dpp_pkg: shared types and constants for the debounced power protection block
// holds event codes, register indexes, hold defaults and the result struct
// no dependencies
package dpp_pkg;

  // sample and limit width
  localparam int unsigned SAMPLE_W = 16;
  // number of protection channels
  localparam int unsigned NUM_CH = 5;
  // trip counter width, holds any hold limit up to 254 plus one
  localparam int unsigned CNT_W = 8;
  // register index width
  localparam int unsigned CFG_IDX_W = 3;

  // default hold limits
  localparam int unsigned OV_HOLD_DEF = 10;
  localparam int unsigned UV_HOLD_DEF = 10;
  localparam int unsigned OC_HOLD_DEF = 10;
  localparam int unsigned SC_HOLD_DEF = 2;

  // channel order, also the bit order of the fault flags
  localparam int unsigned CH_VOUT_OV = 0;
  localparam int unsigned CH_VIN_OV  = 1;
  localparam int unsigned CH_VIN_UV  = 2;
  localparam int unsigned CH_OCP     = 3;
  localparam int unsigned CH_SHORT   = 4;

  // per channel event code
  typedef enum logic [1:0] {
    EV_OK        = 2'd0,
    EV_TRIGGERED = 2'd1,
    EV_RECOVERED = 2'd2
  } event_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOUT_OVER    = 3'd0,
    CFG_VIN_OVER     = 3'd1,
    CFG_VIN_UNDER    = 3'd2,
    CFG_CURRENT_OVER = 3'd3,
    CFG_SHORT_VOLT   = 3'd4,
    CFG_SHORT_AMP    = 3'd5
  } cfg_idx_t;

  // register reset values
  localparam logic [SAMPLE_W-1:0] LIMIT_MAX = '1;
  localparam logic [SAMPLE_W-1:0] LIMIT_MIN = '0;

  // one result beat
  typedef struct packed {
    event_t [NUM_CH-1:0] events;
    logic   [NUM_CH-1:0] faults;
    logic                stop;
  } result_t;

endpackage

// ----- hw/rtl/debounced_power_protection_top.sv -----
// debounced_power_protection_top: five debounced trip channels with fault latches
// one sample set in, one result beat out, skid buffered output
// depends on dpp_pkg
//
// Usage
//   Input channel (in_valid/in_ready) carries one converter sample set per
//   beat: run flag, four 16-bit samples and a flag-clear request. Output
//   channel (out_valid/out_ready) returns one result beat per input beat:
//   five channel events, the latched fault flags and the pwm stop request.
//   A beat accepted at an edge shows on the output after that edge when the
//   output is free. Throughput is one beat per cycle while in_ready is high;
//   all channel logic is a single registered pass of compares and 8-bit counters.
//   When the receiver stalls the output register holds its beat and one
//   more beat lands in the skid register; in_ready then drops until the
//   output drains, so no beat is lost or repeated.
//   Reset (rst, synchronous) clears armed bits, counts, fault latches and both
//   output stages, and loads the limit registers with their defaults. The user
//   writes limit registers via cfg_we/cfg_index/cfg_data only while the block
//   is idle, which it does not check; an index beyond the last register is ignored.
module debounced_power_protection_top #(
  parameter int unsigned OV_HOLD = dpp_pkg::OV_HOLD_DEF,
  parameter int unsigned UV_HOLD = dpp_pkg::UV_HOLD_DEF,
  parameter int unsigned OC_HOLD = dpp_pkg::OC_HOLD_DEF,
  parameter int unsigned SC_HOLD = dpp_pkg::SC_HOLD_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [dpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpp_pkg::SAMPLE_W-1:0]      cfg_data,
  // input beat
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              running,
  input  logic [dpp_pkg::SAMPLE_W-1:0]      vout_sample,
  input  logic [dpp_pkg::SAMPLE_W-1:0]      vin_sample,
  input  logic [dpp_pkg::SAMPLE_W-1:0]      iout_sample,
  input  logic [dpp_pkg::SAMPLE_W-1:0]      short_v_sample,
  input  logic                              clear_faults,
  // result beat
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        vout_ov_event,
  output logic [1:0]                        vin_ov_event,
  output logic [1:0]                        vin_uv_event,
  output logic [1:0]                        ocp_event,
  output logic [1:0]                        short_event,
  output logic [dpp_pkg::NUM_CH-1:0]        fault_latches,
  output logic                              stop_pwm
);

  localparam int unsigned NCH = dpp_pkg::NUM_CH;
  localparam int unsigned CW  = dpp_pkg::CNT_W;

  // hold limit per channel, in channel order
  localparam logic [CW-1:0] HOLD [NCH] = '{
    CW'(OV_HOLD), CW'(OV_HOLD), CW'(UV_HOLD), CW'(OC_HOLD), CW'(SC_HOLD)
  };

  // limit registers
  logic [dpp_pkg::SAMPLE_W-1:0] vout_over_limit;
  logic [dpp_pkg::SAMPLE_W-1:0] vin_over_limit;
  logic [dpp_pkg::SAMPLE_W-1:0] vin_under_limit;
  logic [dpp_pkg::SAMPLE_W-1:0] current_over_limit;
  logic [dpp_pkg::SAMPLE_W-1:0] short_volt_limit;
  logic [dpp_pkg::SAMPLE_W-1:0] short_amp_limit;

  // channel state
  logic [NCH-1:0] armed;
  logic [NCH-1:0] armed_next;
  logic [CW-1:0]  trip_count [NCH];
  logic [CW-1:0]  trip_count_next [NCH];
  logic [NCH-1:0] latched;
  logic [NCH-1:0] latched_next;

  // output stages
  dpp_pkg::result_t res_next;
  dpp_pkg::result_t out_res;
  dpp_pkg::result_t skid_res;
  logic             skid_valid;

  logic           accept;
  logic [NCH-1:0] trips;
  logic [NCH-1:0] armed_eff;
  logic [NCH-1:0] latched_eff;
  logic [CW-1:0]  count_inc;
  logic [NCH-1:0] fired;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  // limit register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vout_over_limit    <= dpp_pkg::LIMIT_MAX;
      vin_over_limit     <= dpp_pkg::LIMIT_MAX;
      vin_under_limit    <= dpp_pkg::LIMIT_MIN;
      current_over_limit <= dpp_pkg::LIMIT_MAX;
      short_volt_limit   <= dpp_pkg::LIMIT_MIN;
      short_amp_limit    <= dpp_pkg::LIMIT_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        dpp_pkg::CFG_VOUT_OVER:    vout_over_limit    <= cfg_data;
        dpp_pkg::CFG_VIN_OVER:     vin_over_limit     <= cfg_data;
        dpp_pkg::CFG_VIN_UNDER:    vin_under_limit    <= cfg_data;
        dpp_pkg::CFG_CURRENT_OVER: current_over_limit <= cfg_data;
        dpp_pkg::CFG_SHORT_VOLT:   short_volt_limit   <= cfg_data;
        dpp_pkg::CFG_SHORT_AMP:    short_amp_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // trip compares, strict on every limit
  always_comb begin
    trips                       = '0;
    trips[dpp_pkg::CH_VOUT_OV]  = vout_sample > vout_over_limit;
    trips[dpp_pkg::CH_VIN_OV]   = vin_sample > vin_over_limit;
    trips[dpp_pkg::CH_VIN_UV]   = vin_sample < vin_under_limit;
    trips[dpp_pkg::CH_OCP]      = iout_sample > current_over_limit;
    trips[dpp_pkg::CH_SHORT]    = (short_v_sample < short_volt_limit) &&
                                  (iout_sample > short_amp_limit);
  end

  // channel step, clear request applied first
  always_comb begin
    armed_eff    = clear_faults ? '0 : armed;
    latched_eff  = clear_faults ? '0 : latched;
    armed_next   = armed_eff;
    latched_next = latched_eff;
    fired        = '0;
    count_inc    = '0;
    res_next     = '0;
    for (int i = 0; i < NCH; i++) begin
      trip_count_next[i] = clear_faults ? '0 : trip_count[i];
      res_next.events[i] = dpp_pkg::EV_OK;
      if (!armed_eff[i]) begin
        if (running && trips[i]) begin
          armed_next[i]      = 1'b1;
          trip_count_next[i] = '0;
        end
      end else if (running && trips[i]) begin
        count_inc = trip_count_next[i] + CW'(1);
        if (count_inc > HOLD[i]) begin
          trip_count_next[i] = '0;
          armed_next[i]      = 1'b0;
          latched_next[i]    = 1'b1;
          fired[i]           = 1'b1;
          res_next.events[i] = dpp_pkg::EV_TRIGGERED;
        end else begin
          trip_count_next[i] = count_inc;
        end
      end else begin
        trip_count_next[i] = '0;
        armed_next[i]      = 1'b0;
        res_next.events[i] = dpp_pkg::EV_RECOVERED;
      end
    end
    res_next.faults = latched_next;
    res_next.stop   = |fired;
  end

  // channel state registers, updated per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      armed   <= '0;
      latched <= '0;
      for (int i = 0; i < NCH; i++) begin
        trip_count[i] <= '0;
      end
    end else if (accept) begin
      armed   <= armed_next;
      latched <= latched_next;
      for (int i = 0; i < NCH; i++) begin
        trip_count[i] <= trip_count_next[i];
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_res   <= res_next;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      skid_res   <= res_next;
      skid_valid <= 1'b1;
    end
  end

  // result fields
  assign vout_ov_event = out_res.events[dpp_pkg::CH_VOUT_OV];
  assign vin_ov_event  = out_res.events[dpp_pkg::CH_VIN_OV];
  assign vin_uv_event  = out_res.events[dpp_pkg::CH_VIN_UV];
  assign ocp_event     = out_res.events[dpp_pkg::CH_OCP];
  assign short_event   = out_res.events[dpp_pkg::CH_SHORT];
  assign fault_latches = out_res.faults;
  assign stop_pwm      = out_res.stop;

  // skid stage only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid beat without output beat");

  // an idle short channel keeps a zero count
  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    !armed[dpp_pkg::CH_SHORT] |-> trip_count[dpp_pkg::CH_SHORT] == '0)
    else $error("short channel count non-zero while disarmed");

  // the short channel count stays within its hold limit
  a_short_count_bound: assert property (@(posedge clk) disable iff (rst)
    trip_count[dpp_pkg::CH_SHORT] <= HOLD[dpp_pkg::CH_SHORT])
    else $error("short channel count beyond hold limit");

  // fault flags only drop on a clear request
  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && !clear_faults |=> (latched & $past(latched)) == $past(latched))
    else $error("fault latch dropped without clear");

  // clear while stopped leaves every channel disarmed and unlatched
  a_clear_stopped: assert property (@(posedge clk) disable iff (rst)
    accept && clear_faults && !running |=> armed == '0 && latched == '0)
    else $error("clear while stopped left state behind");

endmodule

// ----- tb/debounced_power_protection_top_test.sv -----
// debounced_power_protection_top_test: self-checking bench for the five-channel trip qualifier
// a queue-fed driver and a monitor check every result beat against a local channel model
// depends on dpp_pkg and debounced_power_protection_top
`timescale 1ns / 1ps

module debounced_power_protection_top_test;
  import dpp_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned LONG_STALL = 300;
  localparam int unsigned MAX_WAIT = 12;
  localparam int unsigned REPORT_CAP = 50;
  localparam int unsigned SAMPLE_TOP = int'(LIMIT_MAX);
  // indexes past the last limit register, written to show they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    running;
    sample_t vout;
    sample_t vin;
    sample_t iout;
    sample_t vshort;
    logic    clear;
  } sample_set_t;

  typedef struct {
    logic [1:0]        ev [NUM_CH];
    logic [NUM_CH-1:0] faults;
    logic              stop;
  } verdict_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  sample_t cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic running = 1'b0;
  sample_t vout_sample = '0;
  sample_t vin_sample = '0;
  sample_t iout_sample = '0;
  sample_t short_v_sample = '0;
  logic clear_faults = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] vout_ov_event;
  logic [1:0] vin_ov_event;
  logic [1:0] vin_uv_event;
  logic [1:0] ocp_event;
  logic [1:0] short_event;
  logic [NUM_CH-1:0] fault_latches;
  logic stop_pwm;

  debounced_power_protection_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .running        (running),
    .vout_sample    (vout_sample),
    .vin_sample     (vin_sample),
    .iout_sample    (iout_sample),
    .short_v_sample (short_v_sample),
    .clear_faults   (clear_faults),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .vout_ov_event  (vout_ov_event),
    .vin_ov_event   (vin_ov_event),
    .vin_uv_event   (vin_uv_event),
    .ocp_event      (ocp_event),
    .short_event    (short_event),
    .fault_latches  (fault_latches),
    .stop_pwm       (stop_pwm)
  );

  // channel model state and its copy of the limit registers
  sample_t           limit_reg [0:5];
  logic [NUM_CH-1:0] armed;
  logic [CNT_W-1:0]  trip_cnt [NUM_CH];
  logic [NUM_CH-1:0] latched;

  sample_set_t pending_samples [$];
  verdict_t    expected_verdicts [$];
  sample_set_t offered;
  int unsigned mismatch_count = 0;
  int unsigned beat_no = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int          phase_no = -1;
  bit          steady_flow = 1'b0;
  logic        stall_hold = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned hold_limit(int unsigned ch);
    case (ch)
      CH_VOUT_OV, CH_VIN_OV: return OV_HOLD_DEF;
      CH_VIN_UV:             return UV_HOLD_DEF;
      CH_OCP:                return OC_HOLD_DEF;
      default:               return SC_HOLD_DEF;
    endcase
  endfunction

  function automatic string chan_name(int unsigned ch);
    case (ch)
      CH_VOUT_OV: return "vout_ov";
      CH_VIN_OV:  return "vin_ov";
      CH_VIN_UV:  return "vin_uv";
      CH_OCP:     return "ocp";
      default:    return "short";
    endcase
  endfunction

  function automatic void load_defaults();
    limit_reg[CFG_VOUT_OVER]    = LIMIT_MAX;
    limit_reg[CFG_VIN_OVER]     = LIMIT_MAX;
    limit_reg[CFG_VIN_UNDER]    = LIMIT_MIN;
    limit_reg[CFG_CURRENT_OVER] = LIMIT_MAX;
    limit_reg[CFG_SHORT_VOLT]   = LIMIT_MIN;
    limit_reg[CFG_SHORT_AMP]    = LIMIT_MAX;
    armed = '0;
    latched = '0;
    for (int ch = 0; ch < NUM_CH; ch++) trip_cnt[ch] = '0;
  endfunction

  // one channel: arm, count consecutive trips, fire past the hold limit
  function automatic event_t channel_advance(int unsigned ch, logic run, logic trip);
    if (!armed[ch]) begin
      if (run && trip) begin
        armed[ch] = 1'b1;
        trip_cnt[ch] = '0;
      end
      return EV_OK;
    end
    if (run && trip) begin
      trip_cnt[ch] = trip_cnt[ch] + 1'b1;
      if (trip_cnt[ch] > hold_limit(ch)) begin
        trip_cnt[ch] = '0;
        armed[ch] = 1'b0;
        latched[ch] = 1'b1;
        return EV_TRIGGERED;
      end
      return EV_OK;
    end
    // run of trips broken, or converter stopped
    trip_cnt[ch] = '0;
    armed[ch] = 1'b0;
    return EV_RECOVERED;
  endfunction

  function automatic verdict_t protection_step(sample_set_t s);
    logic [NUM_CH-1:0] trip;
    verdict_t v;
    if (s.clear) begin
      latched = '0;
      armed = '0;
      for (int ch = 0; ch < NUM_CH; ch++) trip_cnt[ch] = '0;
    end
    trip[CH_VOUT_OV] = s.vout > limit_reg[CFG_VOUT_OVER];
    trip[CH_VIN_OV]  = s.vin > limit_reg[CFG_VIN_OVER];
    trip[CH_VIN_UV]  = s.vin < limit_reg[CFG_VIN_UNDER];
    trip[CH_OCP]     = s.iout > limit_reg[CFG_CURRENT_OVER];
    trip[CH_SHORT]   = (s.vshort < limit_reg[CFG_SHORT_VOLT]) &&
                       (s.iout > limit_reg[CFG_SHORT_AMP]);
    v.stop = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      v.ev[ch] = channel_advance(ch, s.running, trip[ch]);
      if (v.ev[ch] == EV_TRIGGERED) v.stop = 1'b1;
    end
    v.faults = latched;
    return v;
  endfunction

  function automatic int unsigned draw_wait();
    return steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < REPORT_CAP) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // compare one result beat with the oldest expectation
  task automatic check_result();
    verdict_t want;
    logic [1:0] got_ev [NUM_CH];
    got_ev[CH_VOUT_OV] = vout_ov_event;
    got_ev[CH_VIN_OV]  = vin_ov_event;
    got_ev[CH_VIN_UV]  = vin_uv_event;
    got_ev[CH_OCP]     = ocp_event;
    got_ev[CH_SHORT]   = short_event;
    if (expected_verdicts.size() == 0) begin
      flag_mismatch($sformatf("beat %0d arrived with no expectation waiting", beat_no));
    end else begin
      want = expected_verdicts.pop_front();
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (got_ev[ch] !== want.ev[ch])
          flag_mismatch($sformatf("beat %0d %s event got %0d want %0d",
                                  beat_no, chan_name(ch), got_ev[ch], want.ev[ch]));
      end
      if (fault_latches !== want.faults)
        flag_mismatch($sformatf("beat %0d fault_latches got %b want %b",
                                beat_no, fault_latches, want.faults));
      if (stop_pwm !== want.stop)
        flag_mismatch($sformatf("beat %0d stop_pwm got %b want %b",
                                beat_no, stop_pwm, want.stop));
    end
    beat_no++;
  endtask

  // driver: presents pending samples, predicts each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(protection_step(offered));
        tx_wait = draw_wait();
      end
      if (in_valid && !in_ready) begin
        // hold the beat until taken
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        offered = pending_samples.pop_front();
        in_valid <= 1'b1;
        running <= offered.running;
        vout_sample <= offered.vout;
        vin_sample <= offered.vin;
        iout_sample <= offered.iout;
        short_v_sample <= offered.vshort;
        clear_faults <= offered.clear;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: random back-pressure, checks each accepted result beat
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
        rx_wait = draw_wait();
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0) && !stall_hold;
    end
  end

  // long receiver hold-off in the busiest phase so the input stalls
  initial begin
    wait (phase_no == 2);
    repeat (30) @(posedge clk);
    stall_hold <= 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    stall_hold <= 1'b0;
  end

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input sample_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= CFG_SHORT_AMP) limit_reg[idx] = val;
  endtask

  task automatic set_limits(input sample_t vout_ov, input sample_t vin_ov,
                            input sample_t vin_uv, input sample_t cur_ov,
                            input sample_t sc_volt, input sample_t sc_amp);
    write_limit(CFG_VOUT_OVER, vout_ov);
    write_limit(CFG_VIN_OVER, vin_ov);
    write_limit(CFG_VIN_UNDER, vin_uv);
    write_limit(CFG_CURRENT_OVER, cur_ov);
    write_limit(CFG_SHORT_VOLT, sc_volt);
    write_limit(CFG_SHORT_AMP, sc_amp);
  endtask

  task automatic randomise_limits();
    sample_t under;
    under = sample_t'($urandom_range(0, SAMPLE_TOP / 2));
    set_limits(sample_t'($urandom), sample_t'($urandom_range(under, SAMPLE_TOP)), under,
               sample_t'($urandom), sample_t'($urandom), sample_t'($urandom));
  endtask

  // wait until every beat is through, then let the pipeline settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_verdicts.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_sample(input logic run, input sample_t vo, input sample_t vi,
                             input sample_t io, input sample_t vs, input logic clr);
    sample_set_t s;
    s.running = run;
    s.vout = vo;
    s.vin = vi;
    s.iout = io;
    s.vshort = vs;
    s.clear = clr;
    pending_samples.push_back(s);
  endtask

  // value helpers for trip and no-trip regions, with limit hits now and then
  function automatic sample_t value_above(sample_t lim);
    return (lim == LIMIT_MAX) ? LIMIT_MAX : sample_t'($urandom_range(int'(lim) + 1, SAMPLE_TOP));
  endfunction

  function automatic sample_t value_below(sample_t lim);
    return (lim == LIMIT_MIN) ? LIMIT_MIN : sample_t'($urandom_range(0, int'(lim) - 1));
  endfunction

  function automatic sample_t value_upto(sample_t lim);
    return ($urandom_range(0, 5) == 0) ? lim : sample_t'($urandom_range(0, lim));
  endfunction

  function automatic sample_t value_from(sample_t lim);
    return ($urandom_range(0, 5) == 0) ? lim : sample_t'($urandom_range(lim, SAMPLE_TOP));
  endfunction

  function automatic sample_t vin_inside_band();
    sample_t lo;
    sample_t hi;
    lo = limit_reg[CFG_VIN_UNDER];
    hi = limit_reg[CFG_VIN_OVER];
    if (lo > hi) return sample_t'($urandom);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return sample_t'($urandom_range(lo, hi));
    endcase
  endfunction

  // one run of samples holding a chosen set of channels in trip, plus noise
  function automatic int unsigned queue_episode();
    logic [NUM_CH-1:0] want;
    int unsigned len;
    sample_t floor_i;
    sample_set_t s;
    want = NUM_CH'($urandom_range(0, (1 << NUM_CH) - 1));
    len = $urandom_range(1, 30);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 6) == 0) begin
        s = sample_set_t'({$urandom, $urandom, $urandom});
      end else begin
        s.running = ($urandom_range(0, 24) != 0);
        s.clear = ($urandom_range(0, 49) == 0);
        s.vout = want[CH_VOUT_OV] ? value_above(limit_reg[CFG_VOUT_OVER])
                                  : value_upto(limit_reg[CFG_VOUT_OVER]);
        if (want[CH_VIN_OV]) s.vin = value_above(limit_reg[CFG_VIN_OVER]);
        else if (want[CH_VIN_UV]) s.vin = value_below(limit_reg[CFG_VIN_UNDER]);
        else s.vin = vin_inside_band();
        if (want[CH_OCP] && want[CH_SHORT])
          floor_i = (limit_reg[CFG_CURRENT_OVER] > limit_reg[CFG_SHORT_AMP]) ?
                    limit_reg[CFG_CURRENT_OVER] : limit_reg[CFG_SHORT_AMP];
        else if (want[CH_OCP]) floor_i = limit_reg[CFG_CURRENT_OVER];
        else floor_i = limit_reg[CFG_SHORT_AMP];
        if (want[CH_OCP] || want[CH_SHORT]) s.iout = value_above(floor_i);
        else s.iout = value_upto((limit_reg[CFG_CURRENT_OVER] < limit_reg[CFG_SHORT_AMP]) ?
                                 limit_reg[CFG_CURRENT_OVER] : limit_reg[CFG_SHORT_AMP]);
        s.vshort = want[CH_SHORT] ? value_below(limit_reg[CFG_SHORT_VOLT])
                                  : value_from(limit_reg[CFG_SHORT_VOLT]);
      end
      pending_samples.push_back(s);
    end
    return len;
  endfunction

  task automatic random_phase(input int unsigned target);
    int unsigned queued;
    queued = 0;
    while (queued < target) queued += queue_episode();
    wait_drained();
  endtask

  // stimulus: reset, directed corners, then random phases over several limit sets
  initial begin
    load_defaults();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset limits: nothing can trip
    phase_no = 0;
    push_sample(1'b1, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, 1'b0);
    push_sample(1'b1, LIMIT_MIN, LIMIT_MIN, LIMIT_MIN, LIMIT_MIN, 1'b0);
    wait_drained();

    // writes past the last register must leave the limits alone
    write_limit(CFG_SPARE_LO, LIMIT_MIN);
    write_limit(CFG_SPARE_HI, LIMIT_MIN);
    set_limits(16'd1000, 16'd2000, 16'd500, 16'd3000, 16'd400, 16'd2500);

    // all fields high arms three channels, then running off recovers them
    push_sample(1'b1, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, 1'b0);
    push_sample(1'b0, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, 1'b0);
    // samples equal to the limits are not trips
    push_sample(1'b1, 16'd1000, 16'd2000, 16'd3000, 16'd400, 1'b0);
    push_sample(1'b1, LIMIT_MIN, LIMIT_MIN, LIMIT_MIN, LIMIT_MIN, 1'b0);
    push_sample(1'b1, 16'd1000, 16'd500, 16'd2500, 16'd399, 1'b0);
    // held short: short fires three times, overcurrent once, on the same run
    repeat (12) push_sample(1'b1, LIMIT_MIN, 16'd1000, LIMIT_MAX, LIMIT_MIN, 1'b0);
    // flag clear together with fresh trips
    push_sample(1'b1, 16'd2000, 16'd1000, LIMIT_MIN, LIMIT_MIN, 1'b1);
    push_sample(1'b1, LIMIT_MIN, LIMIT_MIN, LIMIT_MIN, LIMIT_MAX, 1'b1);
    push_sample(1'b0, LIMIT_MIN, LIMIT_MIN, LIMIT_MIN, LIMIT_MIN, 1'b0);
    wait_drained();

    phase_no = 1;
    set_limits(LIMIT_MIN, LIMIT_MIN, LIMIT_MIN, LIMIT_MIN, LIMIT_MIN, LIMIT_MIN);
    random_phase(110);

    phase_no = 2;
    randomise_limits();
    random_phase(200);

    phase_no = 3;
    steady_flow = 1'b1;
    set_limits(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
    random_phase(110);
    steady_flow = 1'b0;

    phase_no = 4;
    randomise_limits();
    random_phase(110);

    phase_no = 5;
    set_limits(LIMIT_MAX, LIMIT_MIN, LIMIT_MAX, LIMIT_MIN, LIMIT_MAX, LIMIT_MIN);
    random_phase(110);

    phase_no = 6;
    randomise_limits();
    random_phase(110);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
